[sv/fpt_pkg.sv]
`default_nettype none

package fpt_pkg;

	localparam int NUM_FRAMES_DEF       = 4;
	localparam int PAGE_OFFSET_BITS_DEF = 8;
	localparam int VADDR_BITS_DEF       = 12;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

[sv/fpt_req_if.sv]
`default_nettype none

interface fpt_req_if #(
	parameter int VA_W = fpt_pkg::VADDR_BITS_DEF
);
	logic            valid;
	logic            ready;
	logic [VA_W-1:0] virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink   (input valid, input virtual_address, output ready);
endinterface

`default_nettype wire

[sv/fpt_rsp_if.sv]
`default_nettype none

interface fpt_rsp_if #(
	parameter int FRAME_W = $clog2(fpt_pkg::NUM_FRAMES_DEF),
	parameter int PA_W    = FRAME_W + fpt_pkg::PAGE_OFFSET_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [PA_W-1:0]    physical_address;
	logic               page_fault;
	logic [FRAME_W-1:0] frame_index;

	modport source (output valid, output physical_address, output page_fault,
		output frame_index, input ready);
	modport sink   (input valid, input physical_address, input page_fault,
		input frame_index, output ready);
endinterface

`default_nettype wire

[sv/fpt_ctrl.sv]
`default_nettype none

module fpt_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic        rsp_ready,
	output logic             rsp_valid,
	output fpt_pkg::cmd_t    cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_LOOKUP = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;
	logic out_free;

	assign req_ready   = (state_q == S_IDLE);
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == S_LOOKUP) && out_free;
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				// hold while the previous result is still waiting
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[sv/fpt_datapath.sv]
`default_nettype none

module fpt_datapath #(
	parameter int NUM_FRAMES       = fpt_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_OFFSET_BITS = fpt_pkg::PAGE_OFFSET_BITS_DEF,
	parameter int VADDR_BITS       = fpt_pkg::VADDR_BITS_DEF,
	localparam int FRAME_W = $clog2(NUM_FRAMES),
	localparam int PA_W    = FRAME_W + PAGE_OFFSET_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fpt_pkg::cmd_t         cmd,
	input  wire logic [VADDR_BITS-1:0] virtual_address,
	output logic [PA_W-1:0]            physical_address,
	output logic                       page_fault,
	output logic [FRAME_W-1:0]         frame_index
);

	localparam int OFF_W  = (PAGE_OFFSET_BITS < VADDR_BITS) ? PAGE_OFFSET_BITS : VADDR_BITS;
	localparam int PAGE_W = (VADDR_BITS > PAGE_OFFSET_BITS) ?
		(VADDR_BITS - PAGE_OFFSET_BITS) : 1;

	logic [VADDR_BITS-1:0]       va_q;
	logic [PAGE_W-1:0]           frame_page_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]       frame_valid_q;
	logic [FRAME_W-1:0]          fifo_ptr_q;
	logic [PA_W-1:0]             pa_q;
	logic                        fault_q;
	logic [FRAME_W-1:0]          frame_q;

	logic [PAGE_W-1:0]           page;
	logic [PAGE_OFFSET_BITS-1:0] offset;
	logic                        hit;
	logic [FRAME_W-1:0]          hit_frame;
	logic [FRAME_W-1:0]          frame_sel;
	logic [FRAME_W-1:0]          ptr_next;

	generate
		if (VADDR_BITS > PAGE_OFFSET_BITS) begin : g_page
			assign page = va_q[VADDR_BITS-1:PAGE_OFFSET_BITS];
		end else begin : g_no_page
			assign page = '0;
		end
	endgenerate

	assign offset = PAGE_OFFSET_BITS'(va_q[OFF_W-1:0]);

	// lowest matching frame wins
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (frame_valid_q[i] && (frame_page_q[i] == page)) begin
				hit       = 1'b1;
				hit_frame = FRAME_W'(i);
			end
		end
	end

	assign frame_sel = hit ? hit_frame : fifo_ptr_q;
	assign ptr_next  = (fifo_ptr_q == FRAME_W'(NUM_FRAMES - 1)) ? '0 : fifo_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			fifo_ptr_q    <= '0;
		end else if (cmd.commit && !hit) begin
			frame_valid_q[fifo_ptr_q] <= 1'b1;
			fifo_ptr_q                <= ptr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) va_q <= virtual_address;
		if (cmd.commit && !hit) frame_page_q[fifo_ptr_q] <= page;
		if (cmd.commit) begin
			pa_q    <= {frame_sel, offset};
			fault_q <= !hit;
			frame_q <= frame_sel;
		end
	end

	assign physical_address = pa_q;
	assign page_fault       = fault_q;
	assign frame_index      = frame_q;

endmodule

`default_nettype wire

[sv/fifo_page_translator_unit.sv]
// Each item is captured into va_q, then a lookup-and-replace step compares all
//   frames and, on a miss, updates the table and FIFO pointer; no new item is
//   taken until its result is registered onto rsp once the output is free.
// A finished result waits in the output register while the next item is taken.
// Reset clears frame valid bits, the FIFO pointer and the output valid;
//   the frame page table itself is not cleared.
`default_nettype none

module fifo_page_translator_unit #(
	parameter int NUM_FRAMES       = fpt_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_OFFSET_BITS = fpt_pkg::PAGE_OFFSET_BITS_DEF,
	parameter int VADDR_BITS       = fpt_pkg::VADDR_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fpt_req_if.sink      req,
	fpt_rsp_if.source    rsp
);

	fpt_pkg::cmd_t cmd;

	fpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	fpt_datapath #(
		.NUM_FRAMES       (NUM_FRAMES),
		.PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
		.VADDR_BITS       (VADDR_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.virtual_address  (req.virtual_address),
		.physical_address (rsp.physical_address),
		.page_fault       (rsp.page_fault),
		.frame_index      (rsp.frame_index)
	);

	// one item in flight: no new item right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while lookup pending");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("result valid without commit");

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VA_W      = fpt_pkg::VADDR_BITS_DEF;
	localparam int OFF_W     = fpt_pkg::PAGE_OFFSET_BITS_DEF;
	localparam int NF        = fpt_pkg::NUM_FRAMES_DEF;
	localparam int PAGE_W    = VA_W - OFF_W;
	localparam int FRAME_W   = $clog2(NF);
	localparam int PA_W      = FRAME_W + OFF_W;
	localparam int N_RANDOM  = 1150;
	localparam int MAX_GAP   = 10;
	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [PA_W-1:0]    phys_addr;
		logic               fault;
		logic [FRAME_W-1:0] frame;
	} xlat_t;

	// FIFO replacement table mirror plus the queue of translations still owed
	class translation_scoreboard;
		logic [PAGE_W-1:0]  page_of_frame[NF];
		bit                 loaded[NF];
		logic [FRAME_W-1:0] next_victim;
		xlat_t              owed_q[$];
		int                 mismatches;
		int                 checked;
		int                 faults;

		function new();
			for (int i = 0; i < NF; i++) begin
				page_of_frame[i] = '0;
				loaded[i] = 1'b0;
			end
			next_victim = '0;
			mismatches = 0;
			checked = 0;
			faults = 0;
		endfunction

		function void note_input(logic [VA_W-1:0] va);
			logic [PAGE_W-1:0]  page;
			logic [OFF_W-1:0]   offset;
			logic [FRAME_W-1:0] frame;
			bit                 hit;
			xlat_t              exp_x;
			page = va[VA_W-1:OFF_W];
			offset = va[OFF_W-1:0];
			hit = 1'b0;
			frame = '0;
			for (int i = 0; i < NF; i++) begin
				if (!hit && loaded[i] && page_of_frame[i] == page) begin
					hit = 1'b1;
					frame = FRAME_W'(i);
				end
			end
			if (!hit) begin
				frame = next_victim;
				page_of_frame[frame] = page;
				loaded[frame] = 1'b1;
				next_victim = FRAME_W'((int'(frame) + 1) % NF);
			end
			exp_x.phys_addr = {frame, offset};
			exp_x.fault = !hit;
			exp_x.frame = frame;
			owed_q.push_back(exp_x);
		endfunction

		function void check_result(logic [PA_W-1:0] pa, logic pf, logic [FRAME_W-1:0] fi);
			xlat_t exp_x;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected result pa=%h fault=%b frame=%0d", $time, pa, pf, fi);
				return;
			end
			exp_x = owed_q.pop_front();
			checked++;
			if (exp_x.fault)
				faults++;
			if (pa !== exp_x.phys_addr || pf !== exp_x.fault || fi !== exp_x.frame) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: mismatch exp pa=%h fault=%b frame=%0d, got pa=%h fault=%b frame=%0d",
						$time, exp_x.phys_addr, exp_x.fault, exp_x.frame, pa, pf, fi);
			end
		endfunction

		function int owed();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fpt_req_if #(.VA_W(VA_W)) req_ch ();
	fpt_rsp_if #(.PA_W(PA_W), .FRAME_W(FRAME_W)) rsp_ch ();

	fifo_page_translator_unit #(
		.NUM_FRAMES(NF),
		.PAGE_OFFSET_BITS(OFF_W),
		.VADDR_BITS(VA_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	translation_scoreboard sb = new();
	int idle_cycles;
	int sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.virtual_address <= '0;
		rsp_ch.ready <= 1'b0;
	end

	// hold valid across back-to-back items; drop it only for a drawn gap
	task automatic send_addr(input logic [VA_W-1:0] va);
		int gap;
		gap = $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.virtual_address <= va;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_input(va);
		sent++;
	endtask

	task automatic drain_results();
		int gap;
		forever begin
			gap = $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			sb.check_result(rsp_ch.physical_address, rsp_ch.page_fault, rsp_ch.frame_index);
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		drain_results();
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	logic [VA_W-1:0] directed_q[$] = '{
		12'h000, 12'h0FF, 12'hFFF, 12'hF00, 12'h1AB, 12'h2CD,
		12'h3FF, 12'h000, 12'hF80, 12'h155, 12'h800, 12'h7FF,
		12'h2AA, 12'h855, 12'h700, 12'h3FF, 12'h401, 12'h8FE,
		12'hFFF, 12'h000, 12'h7FF, 12'h4FF
	};

	initial begin
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  offset;
		int                ws_base;
		int                ws_size;
		int                pick;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			send_addr(directed_q[i]);

		ws_base = 0;
		ws_size = 3;
		for (int n = 0; n < N_RANDOM; n++) begin
			// shift the working set now and then; sizes above the frame count thrash
			if (n % 150 == 0) begin
				ws_base = $urandom_range(0, (1 << PAGE_W) - 1);
				ws_size = $urandom_range(2, NF + 2);
			end
			pick = $urandom_range(0, 99);
			if (pick < 75)
				page = PAGE_W'((ws_base + $urandom_range(0, ws_size - 1)) % (1 << PAGE_W));
			else
				page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
			pick = $urandom_range(0, 19);
			if (pick == 0)
				offset = '0;
			else if (pick == 1)
				offset = '1;
			else
				offset = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
			send_addr({page, offset});
		end
		req_ch.valid <= 1'b0;

		while (sb.owed() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Translated %0d addresses: %0d checked, %0d page faults, %0d hits.",
			sent, sb.checked, sb.faults, sb.checked - sb.faults);
		$display("Mismatches or unexpected results: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.owed() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
